### hdl/dcmf_pkg.sv
// ----------------------------------------------------------------------------
// dcmf_pkg
// Shared types and constants of the dark channel min filter.
// ----------------------------------------------------------------------------
package dcmf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int FRAME_W    = 11;
    localparam int RADIUS_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

    localparam logic [FRAME_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FRAME_W-1:0]  FRAME_HEIGHT_RST = 11'd480;
    localparam logic [RADIUS_W-1:0] RADIUS_RST       = 3'd7;

    localparam logic [7:0] SAMPLE_MAX = 8'hFF;

    // control flags that travel with a request down the pipeline
    typedef struct packed {
        logic valid;
        logic wr;
        logic emit;
        logic last;
    } t_ctl;

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

### hdl/dcmf_vcell.sv
// ----------------------------------------------------------------------------
// dcmf_vcell
// One vertical cell: a line store that delays the column by one row and folds
// the delayed sample into the running vertical minimum.
// ----------------------------------------------------------------------------
module dcmf_vcell #(
    parameter int MAX_WIDTH = 1024,
    parameter int CELL_IDX  = 0,
    parameter int CW        = 11,
    parameter int SW        = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  dcmf_pkg::t_ctl    i_ctl,
    input  logic [CW-1:0]     i_col,
    input  logic [SW-1:0]     i_vcount,
    input  logic [SW-1:0]     i_hcount,
    input  logic [7:0]        i_shift,
    input  logic [7:0]        i_vmin,
    output dcmf_pkg::t_ctl    o_ctl,
    output logic [CW-1:0]     o_col,
    output logic [SW-1:0]     o_vcount,
    output logic [SW-1:0]     o_hcount,
    output logic [7:0]        o_shift,
    output logic [7:0]        o_vmin
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [7:0]     r_mem [MAX_WIDTH];
    logic [7:0]     r_rd;
    dcmf_pkg::t_ctl r_ctl;
    logic [CW-1:0]  r_col;
    logic [SW-1:0]  r_vcount;
    logic [SW-1:0]  r_hcount;
    logic [7:0]     r_vmin;
    logic [AW-1:0]  addr;

    assign addr = i_col[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_col    <= i_col;
            r_vcount <= i_vcount;
            r_hcount <= i_hcount;
            r_vmin   <= i_vmin;
            r_rd     <= r_mem[addr];
        end
    end

    // read-before-write: the old row moves on, the incoming row takes its place
    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.valid && i_ctl.wr) begin
            r_mem[addr] <= i_shift;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_col    = r_col;
    assign o_vcount = r_vcount;
    assign o_hcount = r_hcount;
    assign o_shift  = r_rd;
    // rows above the frame top and beyond the window are left out
    assign o_vmin   = (SW'(CELL_IDX) < r_vcount) ? dcmf_pkg::min8(r_vmin, r_rd) : r_vmin;

endmodule

### hdl/dcmf_hwin.sv
// ----------------------------------------------------------------------------
// dcmf_hwin
// Horizontal window: a tap line of recent column minima, a masked min tree
// and the output register.
// ----------------------------------------------------------------------------
module dcmf_hwin #(
    parameter int MAX_RADIUS = 7,
    parameter int SW         = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  dcmf_pkg::t_ctl    i_ctl,
    input  logic [SW-1:0]     i_hcount,
    input  logic [7:0]        i_vmin,
    output logic              o_valid,
    output logic [7:0]        o_dark_value,
    output logic              o_last_of_frame
);

    localparam int SPAN = 2 * MAX_RADIUS;
    localparam int LG   = $clog2(SPAN + 1);
    localparam int NP   = 1 << LG;

    logic [7:0] r_tap [SPAN];
    logic       r_valid;
    logic [7:0] r_dark;
    logic       r_last;
    logic [7:0] tree [NP];
    logic [7:0] hmin;

    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.valid) begin
            r_tap[0] <= i_vmin;
            for (int k = 1; k < SPAN; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            tree[i] = dcmf_pkg::SAMPLE_MAX;
        end
        tree[0] = i_vmin;
        // only columns of the current row inside the window count
        for (int i = 1; i <= SPAN; i++) begin
            if (SW'(i) <= i_hcount) begin
                tree[i] = r_tap[i-1];
            end
        end
        for (int l = 0; l < LG; l++) begin
            for (int i = 0; i < (NP >> (l + 1)); i++) begin
                tree[i] = dcmf_pkg::min8(tree[2*i], tree[2*i+1]);
            end
        end
        hmin = tree[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid && i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dark <= hmin;
            r_last <= i_ctl.last;
        end
    end

    assign o_valid         = r_valid;
    assign o_dark_value    = r_dark;
    assign o_last_of_frame = r_last;

endmodule

### hdl/dark_channel_min_filter.sv
// Pipeline: input register, then each line-store cell, then the output register.
// Throughput: one request per cycle; the whole pipeline holds only while the output
// register is full and stalled.
// The vertical window is a chain of 2*MAX_RADIUS line-store cells, one memory port each.
// Reset (synchronous, active low) clears valid bits and grid position, presets config;
// line stores need no clearing, since only rows of the current frame are read.
// ----------------------------------------------------------------------------
// dark_channel_min_filter
// Per-pixel RGB minimum (full scale if i_mode is set), then a clipped square min filter.
// ----------------------------------------------------------------------------
module dark_channel_min_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dcmf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dcmf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_mode,
    input  logic [7:0]                        i_red,
    input  logic [7:0]                        i_green,
    input  logic [7:0]                        i_blue,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [7:0]                        o_dark_value,
    output logic                              o_last_of_frame
);

    localparam int SPAN = 2 * MAX_RADIUS;
    localparam int CW   = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
    localparam int SW   = $clog2(SPAN + 1);
    localparam int RDW  = $clog2(MAX_RADIUS + 1);

    logic [dcmf_pkg::FRAME_W-1:0]  r_frame_width;
    logic [dcmf_pkg::FRAME_W-1:0]  r_frame_height;
    logic [dcmf_pkg::RADIUS_W-1:0] r_radius;

    logic [CW-1:0]  w_eff;
    logic [RW-1:0]  h_eff;
    logic [RDW-1:0] rad_eff;
    logic [SW-1:0]  span2;
    logic [CW-1:0]  row_len;
    logic [RW-1:0]  rows_tot;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic adv, acc, cfg_hit, col_end, row_end, in_col;
    logic [7:0]    min3;
    logic [7:0]    sample;
    logic [SW-1:0] vcount, hcount;

    dcmf_pkg::t_ctl r_s0_ctl;
    logic [CW-1:0]  r_s0_col;
    logic [SW-1:0]  r_s0_vcount;
    logic [SW-1:0]  r_s0_hcount;
    logic [7:0]     r_s0_sample;

    dcmf_pkg::t_ctl w_ctl    [SPAN+1];
    logic [CW-1:0]  w_col    [SPAN+1];
    logic [SW-1:0]  w_vcount [SPAN+1];
    logic [SW-1:0]  w_hcount [SPAN+1];
    logic [7:0]     w_shift  [SPAN+1];
    logic [7:0]     w_vmin   [SPAN+1];

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= dcmf_pkg::FRAME_WIDTH_RST;
            r_frame_height <= dcmf_pkg::FRAME_HEIGHT_RST;
            r_radius       <= dcmf_pkg::RADIUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dcmf_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                dcmf_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                dcmf_pkg::CFG_RADIUS:       r_radius <= i_cfg_data[dcmf_pkg::RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_hit = i_cfg_we && ((i_cfg_index == dcmf_pkg::CFG_FRAME_WIDTH) ||
                                  (i_cfg_index == dcmf_pkg::CFG_FRAME_HEIGHT) ||
                                  (i_cfg_index == dcmf_pkg::CFG_RADIUS));

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = RW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(r_frame_height);
        end
        if (32'(r_radius) > 32'(MAX_RADIUS)) begin
            rad_eff = RDW'(MAX_RADIUS);
        end else begin
            rad_eff = RDW'(r_radius);
        end
    end

    assign span2    = SW'({rad_eff, 1'b0});
    assign row_len  = w_eff + CW'(rad_eff);
    assign rows_tot = h_eff + RW'(rad_eff);

    // ---------------- grid position ----------------
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;
    assign acc     = i_valid && adv;
    assign col_end = (r_col == row_len - CW'(1));
    assign row_end = (r_row == rows_tot - RW'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (acc) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- input stage ----------------
    assign in_col = (r_col < w_eff);
    assign min3   = dcmf_pkg::min8(dcmf_pkg::min8(i_red, i_green), i_blue);
    assign sample = (!i_mode && in_col && (r_row < h_eff)) ? min3 : dcmf_pkg::SAMPLE_MAX;
    // columns past the frame edge carry no stored rows
    assign vcount = !in_col ? '0 : ((r_row < RW'(span2)) ? SW'(r_row) : span2);
    assign hcount = (r_col < CW'(span2)) ? SW'(r_col) : span2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
        end else if (adv) begin
            r_s0_ctl.valid <= acc;
            r_s0_ctl.wr    <= in_col;
            r_s0_ctl.emit  <= (r_row >= RW'(rad_eff)) && (r_col >= CW'(rad_eff));
            r_s0_ctl.last  <= row_end && col_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_col    <= r_col;
            r_s0_vcount <= vcount;
            r_s0_hcount <= hcount;
            r_s0_sample <= sample;
        end
    end

    // ---------------- vertical cell chain ----------------
    assign w_ctl[0]    = r_s0_ctl;
    assign w_col[0]    = r_s0_col;
    assign w_vcount[0] = r_s0_vcount;
    assign w_hcount[0] = r_s0_hcount;
    assign w_shift[0]  = r_s0_sample;
    assign w_vmin[0]   = r_s0_sample;

    for (genvar j = 0; j < SPAN; j++) begin : g_vcell
        dcmf_vcell #(
            .MAX_WIDTH (MAX_WIDTH),
            .CELL_IDX  (j),
            .CW        (CW),
            .SW        (SW)
        ) u_vcell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_ctl    (w_ctl[j]),
            .i_col    (w_col[j]),
            .i_vcount (w_vcount[j]),
            .i_hcount (w_hcount[j]),
            .i_shift  (w_shift[j]),
            .i_vmin   (w_vmin[j]),
            .o_ctl    (w_ctl[j+1]),
            .o_col    (w_col[j+1]),
            .o_vcount (w_vcount[j+1]),
            .o_hcount (w_hcount[j+1]),
            .o_shift  (w_shift[j+1]),
            .o_vmin   (w_vmin[j+1])
        );
    end

    // ---------------- horizontal window and output ----------------
    dcmf_hwin #(
        .MAX_RADIUS (MAX_RADIUS),
        .SW         (SW)
    ) u_hwin (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_ctl           (w_ctl[SPAN]),
        .i_hcount        (w_hcount[SPAN]),
        .i_vmin          (w_vmin[SPAN]),
        .o_valid         (o_valid),
        .o_dark_value    (o_dark_value),
        .o_last_of_frame (o_last_of_frame)
    );

`ifndef NO_ASSERTIONS
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < row_len)
        else $error("column position past row length");

    a_row_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < rows_tot)
        else $error("row position past grid height");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_edge_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_ctl.valid && !r_s0_ctl.wr) |->
            (r_s0_vcount == '0) && (r_s0_sample == dcmf_pkg::SAMPLE_MAX))
        else $error("column outside frame carries stored rows or a real sample");
`endif

endmodule
